>>> rtl/lsd_decimal_radix_sort_unit_assert.svh
// ----------------------------------------------------------------------------
// lsd radix sort assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef LSD_DECIMAL_RADIX_SORT_UNIT_ASSERT_SVH
`define LSD_DECIMAL_RADIX_SORT_UNIT_ASSERT_SVH

// property must hold at every clock outside reset
`define LSD_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// condition must never be seen outside reset
`define LSD_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);

`endif

>>> rtl/lsdrs_pkg.sv
// ----------------------------------------------------------------------------
// lsd radix sort package
// shared constants for the sort unit and its checker
// ----------------------------------------------------------------------------
package lsdrs_pkg;

    localparam int MAX_ITEMS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 31;
    localparam int RADIX_DEF      = 10;
    localparam int DATA_W         = 32;

endpackage

>>> rtl/lsdrs_ram.sv
// ----------------------------------------------------------------------------
// lsd radix sort ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lsdrs_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/lsdrs_div.sv
// ----------------------------------------------------------------------------
// lsd radix sort digit divider
// two stage divide by the radix: reciprocal multiply, then one correction
// ----------------------------------------------------------------------------
module lsdrs_div #(
    parameter int VB    = 31,
    parameter int RADIX = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [VB-1:0]            in_q,
    input  logic [VB-1:0]            in_pay,
    output logic                     out_valid,
    output logic [VB-1:0]            out_quot,
    output logic [$clog2(RADIX)-1:0] out_rem,
    output logic [VB-1:0]            out_pay
);

    localparam int DW = $clog2(RADIX);
    localparam longint unsigned RECIP_L = (64'd1 << VB) / RADIX;
    localparam logic [VB-1:0] RECIP = VB'(RECIP_L);

    logic            v1_reg;
    logic [VB-1:0]   q1_reg;
    logic [VB-1:0]   p1_reg;
    logic [2*VB-1:0] prod1_reg;

    logic [VB-1:0] qh;
    logic [VB-1:0] qhr;
    logic [VB-1:0] rem_raw;
    logic          corr;

    assign qh      = prod1_reg[2*VB-1:VB];
    assign qhr     = VB'(qh * VB'(RADIX));
    assign rem_raw = q1_reg - qhr;
    assign corr    = rem_raw >= VB'(RADIX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q1_reg    <= in_q;
        p1_reg    <= in_pay;
        prod1_reg <= (2*VB)'(in_q) * (2*VB)'(RECIP);
        out_pay   <= p1_reg;
        if (corr)
        begin
            out_quot <= qh + VB'(1);
            out_rem  <= DW'(rem_raw - VB'(RADIX));
        end
        else
        begin
            out_quot <= qh;
            out_rem  <= DW'(rem_raw);
        end
    end

endmodule

>>> rtl/lsd_decimal_radix_sort_unit.sv
// ----------------------------------------------------------------------------
// lsd radix sort unit
// collects a set of values, sorts them by least significant digit first
// counting passes in base RADIX and streams them out in ascending order
// ----------------------------------------------------------------------------
// Loading accepts one transaction per cycle; the transaction with tlast closes
// the set (values beyond MAX_ITEMS are dropped and flagged on tuser). Each
// pass is a histogram read sweep and a backward scatter sweep through one
// memory port, each behind the memory and the two stage divider, plus a
// serial prefix sum over the counts. The number of passes is the digit count
// of the set's maximum (none when it is zero). Results then leave one at a
// time, each held on the output until taken before the next is read. No new
// set is taken until the last result has been sent.
module lsd_decimal_radix_sort_unit
    import lsdrs_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int RADIX      = RADIX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // value[30:0], zero
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // sorted_value[30:0], zero
    output logic              m_tuser,   // overflow
    output logic              m_tlast
);

    localparam int VB = VALUE_BITS;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int DW = $clog2(RADIX);
    localparam int MW = 2 * VB;

    typedef enum logic [3:0] {
        S_LOAD,
        S_HIST,
        S_PREFIX,
        S_SCAT,
        S_MAX_ISSUE,
        S_MAX_WAIT,
        S_OUT_RD,
        S_OUT_WAIT,
        S_OUT_SEND
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [VB-1:0]   max_reg;
    logic            drop_reg;
    logic            src_reg;
    logic [CW-1:0]   issue_reg;
    logic [CW-1:0]   done_reg;
    logic [CW-1:0]   out_idx_reg;
    logic [DW-1:0]   pidx_reg;
    logic            rvalid_reg;
    logic [CW-1:0]   cnt_reg [RADIX];

    logic [VB-1:0]   vin;
    logic            has_room;
    logic [VB-1:0]   max_next;
    logic            issue;
    logic [CW-1:0]   rd_idx;
    logic [AW-1:0]   raddr;
    logic [MW-1:0]   rd0;
    logic [MW-1:0]   rd1;
    logic [MW-1:0]   src_data;
    logic            div_in_valid;
    logic [VB-1:0]   div_in_q;
    logic            dv;
    logic [VB-1:0]   dq;
    logic [DW-1:0]   dr;
    logic [VB-1:0]   dp;
    logic [CW-1:0]   pos;
    logic            load_we;
    logic            scat_we;
    logic            we0;
    logic            we1;
    logic [AW-1:0]   waddr;
    logic [MW-1:0]   wdata;

    assign vin      = s_tdata[VB-1:0];
    assign has_room = count_reg < CW'(MAX_ITEMS);
    assign max_next = (has_room && vin > max_reg) ? vin : max_reg;
    assign s_tready = state_reg == S_LOAD;

    assign issue = (state_reg == S_HIST || state_reg == S_SCAT) && issue_reg != count_reg;

    always_comb
    begin
        unique case (state_reg)
            S_SCAT:   rd_idx = count_reg - CW'(1) - issue_reg;
            S_OUT_RD: rd_idx = out_idx_reg;
            default:  rd_idx = issue_reg;
        endcase
    end

    assign raddr    = rd_idx[AW-1:0];
    assign src_data = src_reg ? rd1 : rd0;

    assign div_in_valid = rvalid_reg || state_reg == S_MAX_ISSUE;
    assign div_in_q     = (state_reg == S_MAX_ISSUE) ? max_reg : src_data[MW-1:VB];

    assign pos     = cnt_reg[dr] - CW'(1);
    assign load_we = s_tvalid && s_tready && has_room;
    assign scat_we = dv && state_reg == S_SCAT;
    assign we0     = (load_we && !src_reg) || (scat_we && src_reg);
    assign we1     = (load_we && src_reg) || (scat_we && !src_reg);
    assign waddr   = load_we ? count_reg[AW-1:0] : pos[AW-1:0];
    assign wdata   = load_we ? {vin, vin} : {dq, dp};

    lsdrs_ram #(.WIDTH(MW), .DEPTH(MAX_ITEMS)) u_ram0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd0)
    );

    lsdrs_ram #(.WIDTH(MW), .DEPTH(MAX_ITEMS)) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd1)
    );

    lsdrs_div #(.VB(VB), .RADIX(RADIX)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_in_valid),
        .in_q      (div_in_q),
        .in_pay    (src_data[VB-1:0]),
        .out_valid (dv),
        .out_quot  (dq),
        .out_rem   (dr),
        .out_pay   (dp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            max_reg     <= '0;
            drop_reg    <= 1'b0;
            src_reg     <= 1'b0;
            issue_reg   <= '0;
            done_reg    <= '0;
            out_idx_reg <= '0;
            pidx_reg    <= '0;
            rvalid_reg  <= 1'b0;
            m_tvalid    <= 1'b0;
            m_tdata     <= '0;
            m_tuser     <= 1'b0;
            m_tlast     <= 1'b0;
            for (int i = 0; i < RADIX; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            rvalid_reg <= issue;
            if (issue)
            begin
                issue_reg <= issue_reg + CW'(1);
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (s_tvalid)
                    begin
                        max_reg <= max_next;
                        if (has_room)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                        if (s_tlast)
                        begin
                            issue_reg   <= '0;
                            done_reg    <= '0;
                            out_idx_reg <= '0;
                            for (int i = 0; i < RADIX; i++)
                            begin
                                cnt_reg[i] <= '0;
                            end
                            state_reg <= (max_next == '0) ? S_OUT_RD : S_HIST;
                        end
                    end
                end
                S_HIST:
                begin
                    if (dv)
                    begin
                        cnt_reg[dr] <= cnt_reg[dr] + CW'(1);
                        done_reg    <= done_reg + CW'(1);
                        if (done_reg + CW'(1) == count_reg)
                        begin
                            pidx_reg  <= DW'(1);
                            state_reg <= S_PREFIX;
                        end
                    end
                end
                S_PREFIX:
                begin
                    cnt_reg[pidx_reg] <= cnt_reg[pidx_reg] + cnt_reg[pidx_reg - DW'(1)];
                    if (pidx_reg == DW'(RADIX - 1))
                    begin
                        issue_reg <= '0;
                        done_reg  <= '0;
                        state_reg <= S_SCAT;
                    end
                    else
                    begin
                        pidx_reg <= pidx_reg + DW'(1);
                    end
                end
                S_SCAT:
                begin
                    if (dv)
                    begin
                        cnt_reg[dr] <= pos;
                        done_reg    <= done_reg + CW'(1);
                        if (done_reg + CW'(1) == count_reg)
                        begin
                            src_reg   <= !src_reg;
                            state_reg <= S_MAX_ISSUE;
                        end
                    end
                end
                S_MAX_ISSUE:
                begin
                    state_reg <= S_MAX_WAIT;
                end
                S_MAX_WAIT:
                begin
                    if (dv)
                    begin
                        max_reg   <= dq;
                        issue_reg <= '0;
                        done_reg  <= '0;
                        for (int i = 0; i < RADIX; i++)
                        begin
                            cnt_reg[i] <= '0;
                        end
                        state_reg <= (dq == '0) ? S_OUT_RD : S_HIST;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_WAIT;
                end
                S_OUT_WAIT:
                begin
                    m_tvalid  <= 1'b1;
                    m_tdata   <= DATA_W'(src_data[VB-1:0]);
                    m_tuser   <= drop_reg;
                    m_tlast   <= out_idx_reg == count_reg - CW'(1);
                    state_reg <= S_OUT_SEND;
                end
                S_OUT_SEND:
                begin
                    if (m_tready)
                    begin
                        m_tvalid <= 1'b0;
                        if (m_tlast)
                        begin
                            count_reg <= '0;
                            max_reg   <= '0;
                            drop_reg  <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            out_idx_reg <= out_idx_reg + CW'(1);
                            state_reg   <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

>>> rtl/lsdrs_checker.sv
// ----------------------------------------------------------------------------
// lsd radix sort checker
// port level checks on the sort unit, bound to the top level
// ----------------------------------------------------------------------------
`include "lsd_decimal_radix_sort_unit_assert.svh"

module lsdrs_checker
    import lsdrs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tuser,
    input logic              m_tlast
);

    // a stalled result transaction stays up
    `LSD_ASSERT(a_hold, clk, rst_n,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast),
        "result dropped while stalled")

    // loading and sending never overlap
    `LSD_NEVER(a_excl, clk, rst_n, s_tready && m_tvalid, "input taken during result burst")

    // after the final result the unit is ready for a new set
    `LSD_ASSERT(a_rearm, clk, rst_n, m_tvalid && m_tready && m_tlast |=> s_tready,
        "not ready after burst")

    // the closing transaction starts work, so nothing more is taken next cycle
    `LSD_ASSERT(a_close, clk, rst_n, s_tvalid && s_tready && s_tlast |=> !s_tready,
        "input still taken after set closed")

endmodule

bind lsd_decimal_radix_sort_unit lsdrs_checker u_lsdrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> bench/tb_lsd_decimal_radix_sort_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd radix sort unit testbench
// loads sets of values over the input stream, predicts the ascending burst
// with an independent sorter and checks every output transaction in order
// ----------------------------------------------------------------------------
module tb_lsd_decimal_radix_sort_unit;
    import lsdrs_pkg::*;

    localparam int  CAP       = MAX_ITEMS_DEF;
    localparam int  VB        = VALUE_BITS_DEF;
    localparam int  CYCLE_CAP = 2000000;
    localparam int  N_DIR     = 22;

    typedef struct packed {
        logic [VB-1:0] val;
        logic          lst;
        logic          ovf;
    } sorted_t;

    typedef struct packed {
        logic [VB-1:0] val;
        logic          lst;
        logic          chk;
        logic [VB-1:0] xval;
        logic          xovf;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    sorted_t       sorted_q[$];
    logic [VB-1:0] set_vals[$];
    logic          set_drop;
    int            errors = 0;
    int            seen = 0;
    int            sent = 0;
    int            cycles = 0;
    int            sets_done = 0;
    int            overflow_sets = 0;
    bit            quiet = 1'b0;
    bit            hold_sink = 1'b0;
    stim_row_t     dir_tab[N_DIR];
    logic [VB-1:0] dir_check_val[$];
    logic          dir_check_ovf[$];
    bit            dir_check_on[$];

    always #1 clk = ~clk;

    lsd_decimal_radix_sort_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // stable base-10 lsd sort of the collected set, queues the whole burst
    task automatic predict_burst();
        logic [VB-1:0] a[$];
        logic [VB-1:0] b[$];
        logic [VB-1:0] mx;
        longint unsigned w;
        int cnt[10];
        int d;
        a = set_vals;
        mx = 0;
        foreach (a[i]) if (a[i] > mx) mx = a[i];
        w = 1;
        while (longint'(mx) / w > 0)
        begin
            for (int k = 0; k < 10; k++) cnt[k] = 0;
            foreach (a[i]) cnt[(longint'(a[i]) / w) % 10]++;
            for (int k = 1; k < 10; k++) cnt[k] += cnt[k-1];
            b = a;
            for (int i = a.size() - 1; i >= 0; i--)
            begin
                d = int'((longint'(a[i]) / w) % 10);
                cnt[d]--;
                b[cnt[d]] = a[i];
            end
            a = b;
            w = w * 10;
        end
        foreach (a[i])
            sorted_q.insert(sorted_q.size(), sorted_t'{a[i], i == a.size() - 1, set_drop});
        sets_done++;
        if (set_drop) overflow_sets++;
        set_vals.delete();
        set_drop = 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic load_value(input logic [VB-1:0] v, input logic lst);
        if (!quiet)
            while ($urandom_range(99) < 13)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W-VB){1'b0}}, v};
        s_tlast  <= lst;
        sent++;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (set_vals.size() < CAP) set_vals.insert(set_vals.size(), v);
        else set_drop = 1'b1;
        if (lst) predict_burst();
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sorted_q.size() != 0) @(negedge clk);
    endtask

    function automatic logic [VB-1:0] rand_value();
        case ($urandom_range(5))
            0: return VB'($urandom_range(9));
            1: return VB'($urandom_range(999));
            2: return VB'($urandom_range(99999));
            3: return {VB{1'b1}} - VB'($urandom_range(3));
            default: return VB'($urandom());
        endcase
    endfunction

    task automatic load_set(input int n);
        for (int i = 0; i < n; i++) load_value(rand_value(), i == n - 1);
    endtask

    // sink side
    always @(negedge clk)
    begin
        if (hold_sink || !rst_n) m_tready <= 1'b0;
        else if (quiet) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 13);
    end

    always @(posedge clk)
    begin
        sorted_t e;
        cycles++;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen++;
            if (sorted_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected transaction data=%h last=%b user=%b",
                         $time, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                e = sorted_q.pop_front();
                if (m_tdata != {{(DATA_W-VB){1'b0}}, e.val} || m_tlast != e.lst
                    || m_tuser != e.ovf)
                begin
                    errors++;
                    $display("%0t mismatch exp data=%h last=%b user=%b got data=%h last=%b user=%b",
                             $time, e.val, e.lst, e.ovf, m_tdata, m_tlast, m_tuser);
                end
                if (dir_check_on.size() != 0)
                begin
                    if (dir_check_on[0] && (e.val != dir_check_val[0]
                        || e.ovf != dir_check_ovf[0]))
                    begin
                        errors++;
                        $display("%0t table mismatch exp data=%h user=%b got data=%h user=%b",
                                 $time, dir_check_val[0], dir_check_ovf[0], e.val, e.ovf);
                    end
                    void'(dir_check_on.pop_front());
                    void'(dir_check_val.pop_front());
                    void'(dir_check_ovf.pop_front());
                end
            end
        end
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int tail;
        logic [VB-1:0] mx;
        mx = {VB{1'b1}};
        set_drop = 1'b0;
        // directed table: val, last, check, expected value, expected overflow
        dir_tab[0]  = '{0, 1'b1, 1'b1, 0, 1'b0};
        dir_tab[1]  = '{mx, 1'b1, 1'b1, mx, 1'b0};
        dir_tab[2]  = '{0, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[3]  = '{0, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[4]  = '{0, 1'b1, 1'b0, 0, 1'b0};
        dir_tab[5]  = '{mx, 1'b0, 1'b1, 0, 1'b0};
        dir_tab[6]  = '{0, 1'b1, 1'b1, mx, 1'b0};
        dir_tab[7]  = '{170, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[8]  = '{45, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[9]  = '{75, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[10] = '{90, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[11] = '{802, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[12] = '{24, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[13] = '{2, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[14] = '{66, 1'b1, 1'b0, 0, 1'b0};
        dir_tab[15] = '{1000000000, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[16] = '{999999999, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[17] = '{1000000000, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[18] = '{31'h2AAAAAAA, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[19] = '{31'h55555555, 1'b1, 1'b0, 0, 1'b0};
        dir_tab[20] = '{9, 1'b0, 1'b0, 0, 1'b0};
        dir_tab[21] = '{10, 1'b1, 1'b0, 0, 1'b0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_tab[i].lst)
                for (int k = 0; k <= set_vals.size(); k++)
                begin
                    dir_check_on.insert(dir_check_on.size(), dir_tab[i].chk);
                    dir_check_val.insert(dir_check_val.size(),
                                         k == 0 ? (i == 6 ? 0 : dir_tab[i].xval)
                                                : dir_tab[i].xval);
                    dir_check_ovf.insert(dir_check_ovf.size(), dir_tab[i].xovf);
                end
            load_value(dir_tab[i].val, dir_tab[i].lst);
        end
        wait_drained();
        dir_check_on.delete();
        // store full: 64 held plus dropped ones, last on a dropped item
        for (int i = 0; i < CAP + 3; i++) load_value(rand_value(), i == CAP + 2);
        wait_drained();
        // long sink stall while two sets are loaded, so the block backs up
        fork
            begin
                hold_sink = 1'b1;
                repeat (600) @(posedge clk);
                hold_sink = 1'b0;
                @(negedge clk);
            end
            begin
                load_set(5);
                load_set(4);
            end
        join
        wait_drained();
        // random sets, mostly small, a few full
        while (sent < 360 && cycles < CYCLE_CAP / 2)
        begin
            quiet = ($urandom_range(9) == 0);
            case ($urandom_range(9))
                0: load_set(CAP);
                1: load_set(CAP + $urandom_range(1, 4));
                2: load_set(1);
                default: load_set($urandom_range(2, 12));
            endcase
            if ($urandom_range(7) == 0) wait_drained();
            if (sets_done > 60) break;
        end
        quiet = 1'b0;
        wait_drained();
        tail = 0;
        while (tail < 200)
        begin
            @(posedge clk);
            tail++;
        end
        $display("covered %0d sets, %0d with dropped elements, %0d sorted results",
                 sets_done, overflow_sets, seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
